// File: design/mau_pkg.sv
package mau_pkg;

   localparam int MOD_BITS_DEF = 31;
   localparam int EXP_BITS_DEF = 64;
   localparam int OPERAND_BITS = 64;
   localparam int CSR_BITS     = 31;
   localparam logic [CSR_BITS-1:0] MODULUS_RESET = 31'd998244353;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4,
      OP_INV = 3'd5,
      OP_NEG = 3'd6,
      OP_EQU = 3'd7
   } op_type;

   // datapath register load selects
   typedef enum logic [2:0] {
      SEL_HOLD   = 3'd0,
      SEL_LOAD   = 3'd1,
      SEL_RED_A  = 3'd2,
      SEL_RED_B  = 3'd3,
      SEL_MUL_AA = 3'd4,
      SEL_MUL_AB = 3'd5,
      SEL_FINAL  = 3'd6,
      SEL_INVSET = 3'd7
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_A_WAIT,
      ST_RED_B,
      ST_RED_B_WAIT,
      ST_PREP,
      ST_SQ,
      ST_SQ_WAIT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_NEXT,
      ST_FINAL,
      ST_FINAL_WAIT,
      ST_OUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     load;        // capture request
      logic     div_start;   // start remainder unit
      sel_type  div_src;     // operand selection for divider
      sel_type  wr_sel;      // writeback select: divider result or power-pass load
      logic     exp_load;    // load exponent for the current power pass
      logic     exp_shift;   // advance exponent bit
      logic     inv_pass;    // set up inverse pass (base = acc, exp = m-2)
      logic     out_set;     // compute output
   } cmd_type;

   typedef struct packed {
      logic    div_done;
      logic    exp_bit;
      logic    exp_last;
      logic    need_pow;
      logic    need_inv2;    // pow with negative exponent
      logic    inv_done;     // second pass already taken
      op_type  op;
   } status_type;

endpackage

// File: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: one request (op code, two signed 64-bit operands)
// gives one response with the result reduced modulo the csr modulus. Requests
// are handled one at a time. Every modular reduction runs through a shared
// restoring remainder unit that retires one bit per cycle. Pow, inv and div
// run one square-and-multiply pass over the exponent, and pow with a
// negative exponent runs a second, inverse pass. Write the modulus only
// while no request is in flight.
module modular_arithmetic_unit #(
   parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
   parameter int EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic signed [63:0] req_operand_a,
   input  logic signed [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_result,
   output logic        rsp_is_equal,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_modulus
);
   mau_pkg::cmd_type    cmd;
   mau_pkg::status_type status;
   logic [mau_pkg::CSR_BITS-1:0] modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mau_pkg::MODULUS_RESET;
      end else if (csr_valid && csr_ready) begin
         modulus_ff <= csr_modulus;
      end
   end

   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mau_datapath #(
      .MOD_BITS (MOD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .modulus       (modulus_ff),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .result        (rsp_result),
      .is_equal      (rsp_is_equal)
   );
endmodule

// File: design/mau_datapath.sv
module mau_datapath #(
   parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
   parameter int EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mau_pkg::cmd_type                    cmd,
   output mau_pkg::status_type                 status,
   input  logic [mau_pkg::CSR_BITS-1:0]        modulus,
   input  logic [2:0]                          req_type,
   input  logic signed [mau_pkg::OPERAND_BITS-1:0] req_operand_a,
   input  logic signed [mau_pkg::OPERAND_BITS-1:0] req_operand_b,
   output logic [mau_pkg::CSR_BITS-1:0]        result,
   output logic                                is_equal
);
   localparam int OB = mau_pkg::OPERAND_BITS;
   localparam int PB = 2 * MOD_BITS;
   localparam int DB = (OB > PB) ? OB : PB;
   localparam int CW = $clog2(DB + 1);
   localparam int EW = $clog2(EXP_BITS + 1);

   logic [MOD_BITS-1:0] m_eff;
   logic [MOD_BITS-1:0] m_raw;
   assign m_raw = modulus[MOD_BITS-1:0];
   assign m_eff = (m_raw == '0) ? MOD_BITS'(1) : m_raw;

   mau_pkg::op_type op_ff;
   logic [OB-1:0] a_ff, b_ff;
   logic [MOD_BITS-1:0] x_ff, y_ff, acc_ff, base_ff;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [EW-1:0] ecnt_ff, ecnt_in;
   logic inv_done_ff;
   logic [MOD_BITS-1:0] res_ff;
   logic eq_ff;

   // restoring remainder unit, one bit per cycle
   logic [DB-1:0] dnum_ff, dnum_in;
   logic [MOD_BITS:0] drem_ff, drem_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic dbusy_ff, dbusy_in;
   logic ddone_ff, ddone_in;
   logic [MOD_BITS+1:0] dshift;
   logic [MOD_BITS-1:0] rem_pos, rem_fix;
   logic [DB-1:0] src;
   logic [OB-1:0] mag_a, mag_b;
   logic neg_sel;
   logic neg_sel_ff;
   logic [PB-1:0] prod;

   assign mag_a = a_ff[OB-1] ? (~a_ff + OB'(1)) : a_ff;
   assign mag_b = b_ff[OB-1] ? (~b_ff + OB'(1)) : b_ff;

   always_comb begin
      src = '0;
      neg_sel = 1'b0;
      prod = '0;
      case (cmd.div_src)
         mau_pkg::SEL_RED_A: begin
            src = DB'(mag_a);
            neg_sel = a_ff[OB-1];
         end
         mau_pkg::SEL_RED_B: begin
            src = DB'(mag_b);
            neg_sel = b_ff[OB-1];
         end
         mau_pkg::SEL_MUL_AA: begin
            prod = PB'(acc_ff) * PB'(acc_ff);
            src = DB'(prod);
         end
         mau_pkg::SEL_MUL_AB: begin
            prod = PB'(acc_ff) * PB'(base_ff);
            src = DB'(prod);
         end
         mau_pkg::SEL_FINAL: begin
            prod = PB'(x_ff) * PB'(acc_ff);
            src = DB'(prod);
         end
         default: begin
            src = '0;
         end
      endcase
   end

   assign dshift = {drem_ff, dnum_ff[DB-1]};
   always_comb begin
      dnum_in = dnum_ff;
      drem_in = drem_ff;
      dcnt_in = dcnt_ff;
      dbusy_in = dbusy_ff;
      ddone_in = 1'b0;
      if (cmd.div_start) begin
         dnum_in = src;
         drem_in = '0;
         dcnt_in = CW'(DB);
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         dnum_in = {dnum_ff[DB-2:0], 1'b0};
         if (dshift >= {2'b00, m_eff}) begin
            drem_in = (MOD_BITS+1)'(dshift - {2'b00, m_eff});
         end else begin
            drem_in = dshift[MOD_BITS:0];
         end
         dcnt_in = dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) begin
            dbusy_in = 1'b0;
            ddone_in = 1'b1;
         end
      end
   end

   assign rem_pos = drem_ff[MOD_BITS-1:0];
   assign rem_fix = (neg_sel_ff && rem_pos != '0) ? (m_eff - rem_pos) : rem_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in;
         ddone_ff <= ddone_in;
      end
      dnum_ff <= dnum_in;
      drem_ff <= drem_in;
      dcnt_ff <= dcnt_in;
      if (cmd.div_start) begin
         neg_sel_ff <= neg_sel;
      end
   end

   // exponent sequencing
   logic [OB-1:0] pow_mag;
   assign pow_mag = mag_b;
   always_comb begin
      exp_in = exp_ff;
      ecnt_in = ecnt_ff;
      if (cmd.exp_load) begin
         if (inv_done_ff) begin
            exp_in = EXP_BITS'(m_eff - MOD_BITS'(2));
         end else if (op_ff == mau_pkg::OP_POW) begin
            exp_in = pow_mag[EXP_BITS-1:0];
         end else begin
            exp_in = EXP_BITS'(m_eff - MOD_BITS'(2));
         end
         ecnt_in = EW'(EXP_BITS);
      end else if (cmd.exp_shift) begin
         exp_in = {exp_ff[EXP_BITS-2:0], 1'b0};
         ecnt_in = ecnt_ff - EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_done_ff <= 1'b0;
      end else if (cmd.load) begin
         inv_done_ff <= 1'b0;
      end else if (cmd.inv_pass) begin
         inv_done_ff <= 1'b1;
      end
      exp_ff <= exp_in;
      ecnt_ff <= ecnt_in;
      if (cmd.load) begin
         op_ff <= mau_pkg::op_type'(req_type);
         a_ff <= req_operand_a;
         b_ff <= req_operand_b;
      end
      case (cmd.wr_sel)
         mau_pkg::SEL_RED_A: x_ff <= rem_fix;
         mau_pkg::SEL_RED_B: y_ff <= rem_fix;
         // products are never negative, so the sign fix only acts on the reduced operands a and b
         mau_pkg::SEL_MUL_AA,
         mau_pkg::SEL_MUL_AB,
         mau_pkg::SEL_FINAL: acc_ff <= rem_fix;
         mau_pkg::SEL_LOAD: begin
            // start a power pass: acc = 1 mod m
            acc_ff <= (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            if (op_ff == mau_pkg::OP_POW && !inv_done_ff) begin
               base_ff <= x_ff;
            end else if (op_ff == mau_pkg::OP_DIV && !inv_done_ff) begin
               base_ff <= y_ff;
            end else if (inv_done_ff) begin
               base_ff <= acc_ff;
            end else begin
               base_ff <= x_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // result formation
   logic [MOD_BITS:0] sum;
   logic [MOD_BITS-1:0] res_in;
   always_comb begin
      sum = '0;
      res_in = '0;
      case (op_ff)
         mau_pkg::OP_ADD: begin
            sum = {1'b0, x_ff} + {1'b0, y_ff};
            res_in = (sum >= {1'b0, m_eff}) ? MOD_BITS'(sum - {1'b0, m_eff})
                                             : sum[MOD_BITS-1:0];
         end
         mau_pkg::OP_SUB: begin
            res_in = (x_ff >= y_ff) ? (x_ff - y_ff) : (x_ff + m_eff - y_ff);
         end
         mau_pkg::OP_NEG: begin
            res_in = (x_ff == '0) ? '0 : (m_eff - x_ff);
         end
         mau_pkg::OP_EQU: begin
            res_in = '0;
         end
         default: begin
            res_in = acc_ff;
         end
      endcase
      // m < 2 gives inverse 0
      if ((op_ff == mau_pkg::OP_INV || op_ff == mau_pkg::OP_DIV
           || (op_ff == mau_pkg::OP_POW && b_ff[OB-1]))
          && m_eff < MOD_BITS'(2)) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_set) begin
         res_ff <= res_in;
         eq_ff <= (op_ff == mau_pkg::OP_EQU) && (x_ff == y_ff);
      end
   end

   assign result = mau_pkg::CSR_BITS'(res_ff);
   assign is_equal = eq_ff;

   assign status.div_done = ddone_ff;
   assign status.exp_bit = exp_ff[EXP_BITS-1];
   assign status.exp_last = (ecnt_ff == EW'(1));
   assign status.need_pow = (op_ff == mau_pkg::OP_DIV) || (op_ff == mau_pkg::OP_POW)
                            || (op_ff == mau_pkg::OP_INV) || (op_ff == mau_pkg::OP_MUL);
   assign status.need_inv2 = (op_ff == mau_pkg::OP_POW) && b_ff[OB-1];
   assign status.inv_done = inv_done_ff;
   assign status.op = op_ff;
endmodule

// File: design/mau_ctrl.sv
module mau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 csr_ready,
   input  mau_pkg::status_type  status,
   output mau_pkg::cmd_type     cmd
);
   mau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic rsp_take;
   assign rsp_take = !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mau_pkg::ST_IDLE:       if (req_valid) state_in = mau_pkg::ST_RED_A;
         mau_pkg::ST_RED_A:      state_in = mau_pkg::ST_RED_A_WAIT;
         mau_pkg::ST_RED_A_WAIT: if (status.div_done) state_in = mau_pkg::ST_RED_B;
         mau_pkg::ST_RED_B:      state_in = mau_pkg::ST_RED_B_WAIT;
         mau_pkg::ST_RED_B_WAIT: begin
            if (status.div_done) begin
               if (status.op == mau_pkg::OP_MUL) begin
                  state_in = mau_pkg::ST_FINAL;
               end else if (status.need_pow) begin
                  state_in = mau_pkg::ST_PREP;
               end else begin
                  state_in = mau_pkg::ST_OUT;
               end
            end
         end
         mau_pkg::ST_PREP:       state_in = mau_pkg::ST_SQ;
         mau_pkg::ST_SQ:         state_in = mau_pkg::ST_SQ_WAIT;
         mau_pkg::ST_SQ_WAIT: begin
            if (status.div_done) begin
               state_in = status.exp_bit ? mau_pkg::ST_MUL : mau_pkg::ST_NEXT;
            end
         end
         mau_pkg::ST_MUL:        state_in = mau_pkg::ST_MUL_WAIT;
         mau_pkg::ST_MUL_WAIT:   if (status.div_done) state_in = mau_pkg::ST_NEXT;
         mau_pkg::ST_NEXT: begin
            if (!status.exp_last) begin
               state_in = mau_pkg::ST_SQ;
            end else if (status.need_inv2 && !status.inv_done) begin
               state_in = mau_pkg::ST_PREP;
            end else if (status.op == mau_pkg::OP_DIV) begin
               state_in = mau_pkg::ST_FINAL;
            end else begin
               state_in = mau_pkg::ST_OUT;
            end
         end
         mau_pkg::ST_FINAL:      state_in = mau_pkg::ST_FINAL_WAIT;
         mau_pkg::ST_FINAL_WAIT: if (status.div_done) state_in = mau_pkg::ST_OUT;
         mau_pkg::ST_OUT:        state_in = mau_pkg::ST_DONE;
         mau_pkg::ST_DONE:       if (rsp_take) state_in = mau_pkg::ST_IDLE;
         default:                state_in = mau_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         mau_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            cmd.load = req_valid;
         end
         mau_pkg::ST_RED_A: begin
            cmd.div_start = 1'b1;
            cmd.div_src = mau_pkg::SEL_RED_A;
         end
         mau_pkg::ST_RED_A_WAIT: begin
            cmd.div_src = mau_pkg::SEL_RED_A;
            if (status.div_done) cmd.wr_sel = mau_pkg::SEL_RED_A;
         end
         mau_pkg::ST_RED_B: begin
            cmd.div_start = 1'b1;
            cmd.div_src = mau_pkg::SEL_RED_B;
         end
         mau_pkg::ST_RED_B_WAIT: begin
            if (status.div_done) begin
               cmd.wr_sel = mau_pkg::SEL_RED_B;
               // mul: acc becomes y for final x*acc
               if (status.op == mau_pkg::OP_MUL) cmd.wr_sel = mau_pkg::SEL_FINAL;
            end
         end
         mau_pkg::ST_PREP: begin
            cmd.wr_sel = mau_pkg::SEL_LOAD;
            cmd.exp_load = 1'b1;
         end
         mau_pkg::ST_SQ: begin
            cmd.div_start = 1'b1;
            cmd.div_src = mau_pkg::SEL_MUL_AA;
         end
         mau_pkg::ST_SQ_WAIT: if (status.div_done) cmd.wr_sel = mau_pkg::SEL_MUL_AA;
         mau_pkg::ST_MUL: begin
            cmd.div_start = 1'b1;
            cmd.div_src = mau_pkg::SEL_MUL_AB;
         end
         mau_pkg::ST_MUL_WAIT: if (status.div_done) cmd.wr_sel = mau_pkg::SEL_MUL_AB;
         mau_pkg::ST_NEXT: begin
            cmd.exp_shift = 1'b1;
            if (status.exp_last && status.need_inv2 && !status.inv_done) begin
               cmd.inv_pass = 1'b1;
            end
         end
         mau_pkg::ST_FINAL: begin
            cmd.div_start = 1'b1;
            cmd.div_src = mau_pkg::SEL_FINAL;
         end
         mau_pkg::ST_FINAL_WAIT: begin
            if (status.div_done) begin
               cmd.wr_sel = mau_pkg::SEL_FINAL;
            end
         end
         // latch the result once every operand register has settled
         mau_pkg::ST_OUT: begin
            cmd.out_set = 1'b1;
         end
         mau_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end
endmodule
